FILE: rtl/watermark_refill_id_pool_macros.svh
// Assertion macros shared by the ID pool RTL.
// Each property is clocked on clk and disabled while arst_n is low.
`ifndef WATERMARK_REFILL_ID_POOL_MACROS_SVH
`define WATERMARK_REFILL_ID_POOL_MACROS_SVH
`ifndef SYNTHESIS
`define WRIP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
`define WRIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WRIP_ASSERT_ALWAYS(label, prop, msg)
`define WRIP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/wrip_pkg.sv
package wrip_pkg;

	// Width of counts, amounts and the watermark.
	localparam int unsigned COUNT_W = 13;
	// Width of the Q8.8 growth factor.
	localparam int unsigned GROWTH_W = 16;
	// Width of the configuration register index.
	localparam int unsigned REG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_WATERMARK    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_REFILL = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GROWTH       = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_REFILL_CAP   = 2'd3;

	// Operation classes; the first five match the operation codes.
	typedef enum logic [2:0] {
		OP_CHECK     = 3'd0,
		OP_EXTRACT   = 3'd1,
		OP_REINSTALL = 3'd2,
		OP_RESP_ID   = 3'd3,
		OP_RESP_FAIL = 3'd4,
		OP_NOP       = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_EMPTY  = 2'd1,
		ERR_FULL   = 2'd2,
		ERR_NO_REQ = 2'd3
	} err_t;

	typedef enum logic {
		BK_FETCH,
		BK_EXEC
	} back_state_t;

	// Classified command as it travels through the queue.
	typedef struct packed {
		op_t                op;
		logic [COUNT_W-1:0] req;
		logic               last;
		logic               empty;
	} cmd_t;

	// Per-cell refill bookkeeping.
	typedef struct packed {
		logic               pending;
		logic               fresh;
		logic [COUNT_W-1:0] last_count;
		logic [COUNT_W-1:0] tally;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{
		pending:    1'b0,
		fresh:      1'b1,
		last_count: '0,
		tally:      '0
	};

	typedef struct packed {
		logic [COUNT_W-1:0]  watermark;
		logic [COUNT_W-1:0]  first_refill;
		logic [GROWTH_W-1:0] growth;
		logic [COUNT_W-1:0]  refill_cap;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		watermark:    13'd50,
		first_refill: 13'd128,
		growth:       16'd512,
		refill_cap:   13'd4096
	};

endpackage

FILE: rtl/wrip_front.sv
module wrip_front
	import wrip_pkg::*;
#(
	parameter int unsigned NUM_CELLS = 8,
	parameter int unsigned ID_BITS   = 64,
	parameter int unsigned CELL_W    = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic [2:0]         cell_req,
	input  logic [COUNT_W-1:0] requested_count,
	input  logic [ID_BITS-1:0] item_id,
	input  logic               response_last,
	input  logic               response_empty,
	output logic               q_valid,
	input  logic               q_pop,
	output cmd_t               q_cmd,
	output logic [CELL_W-1:0]  q_cell,
	output logic [ID_BITS-1:0] q_id
);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
	localparam int unsigned RED_W  = 9;

	cmd_t               cmd_mem_q  [QDEPTH];
	logic [CELL_W-1:0]  cell_mem_q [QDEPTH];
	logic [ID_BITS-1:0] id_mem_q   [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;
	cmd_t               cmd_in;
	logic [CELL_W-1:0]  cell_in;

	// Folds a cell index into range by repeated subtraction; the input is
	// only three bits, so seven steps always suffice.
	function automatic logic [CELL_W-1:0] fold_cell(input logic [2:0] raw);
		logic [RED_W-1:0] r;
		r = RED_W'(raw);
		for (int k = 0; k < 7; k++) begin
			if (r >= RED_W'(NUM_CELLS)) begin
				r = r - RED_W'(NUM_CELLS);
			end
		end
		return r[CELL_W-1:0];
	endfunction

	assign busy = (cnt_q == QCNT_W'(QDEPTH));
	assign push = start && !busy;

	// Classify the incoming beat.
	always_comb begin
		cmd_in.req   = requested_count;
		cmd_in.last  = response_last;
		cmd_in.empty = response_empty;
		case (operation)
			OP_CHECK:     cmd_in.op = OP_CHECK;
			OP_EXTRACT:   cmd_in.op = OP_EXTRACT;
			OP_REINSTALL: cmd_in.op = OP_REINSTALL;
			OP_RESP_ID:   cmd_in.op = OP_RESP_ID;
			OP_RESP_FAIL: cmd_in.op = OP_RESP_FAIL;
			default:      cmd_in.op = OP_NOP;
		endcase
		cell_in = fold_cell(cell_req);
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wr_ptr_q]  <= cmd_in;
			cell_mem_q[wr_ptr_q] <= cell_in;
			id_mem_q[wr_ptr_q]   <= item_id;
		end
	end

	// Queue pointers and fill count; the depth is a power of two, so the
	// pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_cmd   = cmd_mem_q[rd_ptr_q];
	assign q_cell  = cell_mem_q[rd_ptr_q];
	assign q_id    = id_mem_q[rd_ptr_q];

endmodule

FILE: rtl/wrip_back.sv
module wrip_back
	import wrip_pkg::*;
#(
	parameter int unsigned NUM_CELLS  = 8,
	parameter int unsigned POOL_DEPTH = 256,
	parameter int unsigned ID_BITS    = 64,
	parameter int unsigned CELL_W     = 3,
	parameter int unsigned LVL_W      = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_valid,
	output logic               q_pop,
	input  cmd_t               q_cmd,
	input  logic [CELL_W-1:0]  q_cell,
	input  logic [ID_BITS-1:0] q_id,
	output logic               done,
	output logic               enough,
	output logic [ID_BITS-1:0] extracted_id,
	output logic               refill_request,
	output logic [COUNT_W-1:0] refill_amount,
	output logic [LVL_W-1:0]   pool_level,
	output logic [1:0]         error_code
);

	localparam int unsigned PTR_W       = $clog2(POOL_DEPTH);
	localparam int unsigned ADDR_W      = CELL_W + PTR_W;
	localparam int unsigned STORE_DEPTH = NUM_CELLS * (2 ** PTR_W);
	localparam int unsigned PROD_W      = COUNT_W + GROWTH_W;
	localparam int unsigned AMT_W       = PROD_W - 8;

	back_state_t        state_q;
	back_state_t        state_d;
	logic               exec;

	// Per-cell state memories and their valid bits.
	logic [LVL_W-1:0]   lvl_mem   [NUM_CELLS];
	ctl_t               ctl_mem   [NUM_CELLS];
	logic [NUM_CELLS-1:0] cell_vld_q;

	// ID store.
	logic [ID_BITS-1:0] store_mem [STORE_DEPTH];

	// Execute stage.
	cmd_t               cmd_s1;
	logic [CELL_W-1:0]  cell_s1;
	logic [ID_BITS-1:0] id_s1;
	logic [LVL_W-1:0]   lvl_rd_s1;
	ctl_t               ctl_rd_s1;
	logic               vld_rd_s1;

	logic [LVL_W-1:0]   cur_lvl;
	ctl_t               cur_ctl;
	logic [LVL_W-1:0]   lvl_new;
	ctl_t               ctl_new;
	logic [COUNT_W-1:0] lvl_wide;
	logic [COUNT_W:0]   thresh;
	logic               full;
	logic [PROD_W-1:0]  prod;
	logic [AMT_W-1:0]   amt_raw;
	logic [COUNT_W-1:0] amt_cap;
	logic [COUNT_W-1:0] tally_nx;
	logic [PTR_W-1:0]   ptr;
	logic               st_we;
	logic               st_re;
	logic               enough_d;
	logic               rreq_d;
	logic [COUNT_W-1:0] ramt_d;
	err_t               err_d;
	logic               ext_d;

	// Result stage.
	logic               done_s2;
	logic               enough_s2;
	logic               rreq_s2;
	logic [COUNT_W-1:0] ramt_s2;
	logic [LVL_W-1:0]   lvl_s2;
	err_t               err_s2;
	logic               ext_s2;
	logic [ID_BITS-1:0] store_rd_s2;

	// Sequencer: fetch the cell state, then execute and write it back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		exec    = 1'b0;
		case (state_q)
			BK_FETCH: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				exec    = 1'b1;
				state_d = BK_FETCH;
			end
			default: state_d = BK_FETCH;
		endcase
	end

	// Capture the command and read the cell state.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1    <= q_cmd;
			cell_s1   <= q_cell;
			id_s1     <= q_id;
			vld_rd_s1 <= cell_vld_q[q_cell];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			lvl_rd_s1 <= lvl_mem[q_cell];
		end
		if (exec) begin
			lvl_mem[cell_s1] <= lvl_new;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_rd_s1 <= ctl_mem[q_cell];
		end
		if (exec) begin
			ctl_mem[cell_s1] <= ctl_new;
		end
	end

	// A cell that was never written reads as its reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
		end else if (exec) begin
			cell_vld_q[cell_s1] <= 1'b1;
		end
	end

	// Next refill amount: the first size, or the last size scaled by the
	// growth factor; either one capped.
	always_comb begin
		prod    = PROD_W'(cur_ctl.last_count) * PROD_W'(cfg.growth);
		amt_raw = cur_ctl.fresh ? AMT_W'(cfg.first_refill) : prod[PROD_W-1:8];
		if (amt_raw > AMT_W'(cfg.refill_cap)) begin
			amt_cap = cfg.refill_cap;
		end else begin
			amt_cap = amt_raw[COUNT_W-1:0];
		end
	end

	// Execute the operation on the addressed cell.
	always_comb begin
		cur_lvl  = vld_rd_s1 ? lvl_rd_s1 : '0;
		cur_ctl  = vld_rd_s1 ? ctl_rd_s1 : CTL_RESET;
		lvl_new  = cur_lvl;
		ctl_new  = cur_ctl;
		lvl_wide = COUNT_W'(cur_lvl);
		thresh   = {1'b0, cmd_s1.req} + {1'b0, cfg.watermark};
		full     = (cur_lvl >= LVL_W'(POOL_DEPTH));
		tally_nx = cur_ctl.tally;
		ptr      = cur_lvl[PTR_W-1:0];
		st_we    = 1'b0;
		st_re    = 1'b0;
		enough_d = 1'b0;
		rreq_d   = 1'b0;
		ramt_d   = '0;
		err_d    = ERR_OK;
		ext_d    = 1'b0;
		case (cmd_s1.op)
			OP_CHECK: begin
				if ({1'b0, lvl_wide} >= thresh) begin
					enough_d = 1'b1;
				end else begin
					if (!cur_ctl.pending) begin
						rreq_d          = 1'b1;
						ramt_d          = amt_cap;
						ctl_new.pending = 1'b1;
						ctl_new.tally   = '0;
					end
					enough_d = (lvl_wide >= cmd_s1.req);
				end
			end
			OP_EXTRACT: begin
				if (cur_lvl == '0) begin
					err_d = ERR_EMPTY;
				end else begin
					lvl_new = cur_lvl - LVL_W'(1);
					ptr     = lvl_new[PTR_W-1:0];
					st_re   = 1'b1;
					ext_d   = 1'b1;
				end
			end
			OP_REINSTALL: begin
				if (full) begin
					err_d = ERR_FULL;
				end else begin
					st_we   = 1'b1;
					lvl_new = cur_lvl + LVL_W'(1);
				end
			end
			OP_RESP_ID: begin
				if (!cur_ctl.pending) begin
					err_d = ERR_NO_REQ;
				end else begin
					if (!cmd_s1.empty) begin
						if (full) begin
							err_d = ERR_FULL;
						end else begin
							st_we   = 1'b1;
							lvl_new = cur_lvl + LVL_W'(1);
						end
						// The tally counts dropped IDs too and saturates.
						if (tally_nx != '1) begin
							tally_nx = tally_nx + COUNT_W'(1);
						end
					end
					ctl_new.tally = tally_nx;
					if (cmd_s1.empty || cmd_s1.last) begin
						ctl_new.last_count = tally_nx;
						ctl_new.fresh      = 1'b0;
						ctl_new.pending    = 1'b0;
						ctl_new.tally      = '0;
					end
				end
			end
			OP_RESP_FAIL: begin
				if (!cur_ctl.pending) begin
					err_d = ERR_NO_REQ;
				end else begin
					ctl_new.pending = 1'b0;
					ctl_new.tally   = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// ID store: push writes at the old level, pop reads at the new level.
	always_ff @(posedge clk) begin
		if (exec && st_we) begin
			store_mem[{cell_s1, ptr}] <= id_s1;
		end
		if (exec && st_re) begin
			store_rd_s2 <= store_mem[ADDR_W'({cell_s1, ptr})];
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= exec;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			enough_s2 <= enough_d;
			rreq_s2   <= rreq_d;
			ramt_s2   <= ramt_d;
			lvl_s2    <= lvl_new;
			err_s2    <= err_d;
			ext_s2    <= ext_d;
		end
	end

	assign done           = done_s2;
	assign enough         = enough_s2;
	assign extracted_id   = ext_s2 ? store_rd_s2 : '0;
	assign refill_request = rreq_s2;
	assign refill_amount  = ramt_s2;
	assign pool_level     = lvl_s2;
	assign error_code     = err_s2;

endmodule

FILE: rtl/watermark_refill_id_pool.sv
// Per-cell LIFO pools of preallocated IDs with a low-watermark refill
// request. An item is taken when start is high and busy is low; up to two
// items wait in a queue in front of the execution unit. The execution unit
// first reads the cell's state memory, then executes and writes it back, and
// takes a new item only after it has written back the last one. The result
// appears with done for exactly one cycle, starting at the clock edge after
// the one at which the item leaves the queue; with an empty queue the item
// is written into the queue, popped into the execute stage, and then its
// result is registered with done. The receiver cannot stall the block: a
// result that is not taken in its done cycle is lost. There is no clearing
// pass after reset; per-cell valid bits stand in for the reset state, and
// the block takes items right away. Configuration may be written only while
// no item is in flight.
`include "watermark_refill_id_pool_macros.svh"

module watermark_refill_id_pool
	import wrip_pkg::*;
#(
	parameter int unsigned NUM_CELLS  = 8,
	parameter int unsigned POOL_DEPTH = 256,
	parameter int unsigned ID_BITS    = 64,
	localparam int unsigned LVL_W     = $clog2(POOL_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           operation,
	input  logic [2:0]           cell_req,
	input  logic [COUNT_W-1:0]   requested_count,
	input  logic [ID_BITS-1:0]   item_id,
	input  logic                 response_last,
	input  logic                 response_empty,
	output logic                 done,
	output logic                 enough,
	output logic [ID_BITS-1:0]   extracted_id,
	output logic                 refill_request,
	output logic [COUNT_W-1:0]   refill_amount,
	output logic [LVL_W-1:0]     pool_level,
	output logic [1:0]           error_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [GROWTH_W-1:0]  cfg_data
);

	localparam int unsigned CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

	cfg_t               cfg_q;
	logic               q_valid;
	logic               q_pop;
	cmd_t               q_cmd;
	logic [CELL_W-1:0]  q_cell;
	logic [ID_BITS-1:0] q_id;

	// Configuration registers; every beat is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WATERMARK:    cfg_q.watermark    <= cfg_data[COUNT_W-1:0];
				REG_FIRST_REFILL: cfg_q.first_refill <= cfg_data[COUNT_W-1:0];
				REG_GROWTH:       cfg_q.growth       <= cfg_data;
				REG_REFILL_CAP:   cfg_q.refill_cap   <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: accept and classify, then queue.
	wrip_front #(
		.NUM_CELLS (NUM_CELLS),
		.ID_BITS   (ID_BITS),
		.CELL_W    (CELL_W)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.cell_req        (cell_req),
		.requested_count (requested_count),
		.item_id         (item_id),
		.response_last   (response_last),
		.response_empty  (response_empty),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_cmd           (q_cmd),
		.q_cell          (q_cell),
		.q_id            (q_id)
	);

	// Back: cell state, ID store and results.
	wrip_back #(
		.NUM_CELLS  (NUM_CELLS),
		.POOL_DEPTH (POOL_DEPTH),
		.ID_BITS    (ID_BITS),
		.CELL_W     (CELL_W),
		.LVL_W      (LVL_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_cmd          (q_cmd),
		.q_cell         (q_cell),
		.q_id           (q_id),
		.done           (done),
		.enough         (enough),
		.extracted_id   (extracted_id),
		.refill_request (refill_request),
		.refill_amount  (refill_amount),
		.pool_level     (pool_level),
		.error_code     (error_code)
	);

	// Each item passes through the fetch and execute states before the next one starts.
	`WRIP_ASSERT_NEXT(a_done_spacing, done, !done, "results closer than two cycles")
	// A refill request only comes from a successful check.
	`WRIP_ASSERT_ALWAYS(a_refill_ok, (done && refill_request) |-> (error_code == ERR_OK), "refill request with an error")
	// The requested amount never exceeds the cap.
	`WRIP_ASSERT_ALWAYS(a_refill_cap, (done && refill_request) |-> (refill_amount <= cfg_q.refill_cap), "refill amount above cap")
	// A pop from an empty pool leaves it empty and returns no ID.
	`WRIP_ASSERT_ALWAYS(a_empty_pop, (done && error_code == ERR_EMPTY) |-> (pool_level == '0 && extracted_id == '0), "empty pop changed state")

endmodule
